// ===== rtl/core/dual_slot_config_record_selector_assert.svh =====
// assertion macros used by the checker file
// needs clk and arst_n in the scope where a macro is used
`ifndef DUAL_SLOT_CONFIG_RECORD_SELECTOR_ASSERT_SVH
`define DUAL_SLOT_CONFIG_RECORD_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DSCRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define DSCRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dscrs_pkg.sv =====
// types, constants and helper functions for the dual-slot record selector
// no dependencies
`timescale 1ns / 1ps

package dscrs_pkg;

	localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
	localparam logic [31:0] REC_MAGIC      = 32'h4642_4331;
	localparam logic [31:0] SHUNT_LIMIT    = 32'd1_000_000;
	localparam logic [31:0] CAPACITY_LIMIT = 32'd10_000_000;
	localparam logic [7:0]  BLANK_BYTE     = 8'hFF;
	localparam logic [4:0]  CRC_END_OFF    = 5'd28;
	localparam logic [4:0]  LAST_OFF       = 5'd31;

	// configuration register indexes
	localparam logic CFG_EXPECTED_VERSION = 1'b0;
	localparam logic CFG_MAX_SLAVE_COUNT  = 1'b1;

	// four-byte field groups of a record, by offset[4:2]
	localparam logic [2:0] GRP_MAGIC    = 3'd0;
	localparam logic [2:0] GRP_VERSION  = 3'd1;
	localparam logic [2:0] GRP_GEN      = 3'd2;
	localparam logic [2:0] GRP_SMALL    = 3'd3;
	localparam logic [2:0] GRP_SHUNT    = 3'd4;
	localparam logic [2:0] GRP_CAPACITY = 3'd5;
	localparam logic [2:0] GRP_RESERVED = 3'd6;
	localparam logic [2:0] GRP_CRC      = 3'd7;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_CORRUPT  = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_BLANK    = 2'd3
	} status_t;

	// one classified byte between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       slot;
		logic [4:0] off;
	} queue_entry_t;

	// captured state of one slot
	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] version;
		logic [31:0] generation;
		logic [31:0] small_fields;
		logic [31:0] shunt;
		logic [31:0] capacity;
		logic        crc_match;
		logic        blank;
	} slot_rec_t;

	// per-slot checks taken in the first decision stage
	typedef struct packed {
		logic valid;
		logic rec_ok;
		logic exp_match;
		logic ver_ne;
		logic blank;
	} slot_flags_t;

	// slot values kept for the second decision stage
	typedef struct packed {
		logic [15:0] version;
		logic [31:0] generation;
		logic [31:0] small_fields;
		logic [31:0] shunt;
		logic [31:0] capacity;
	} slot_view_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
			input logic [7:0] b);
		logic [31:0] w;
		w = word;
		case (lane)
			2'd0:    w[7:0]   = b;
			2'd1:    w[15:8]  = b;
			2'd2:    w[23:16] = b;
			2'd3:    w[31:24] = b;
			default: w = word;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/dscrs_queue.sv =====
// short fifo of classified bytes between front and back
// depends on dscrs_pkg
`timescale 1ns / 1ps

module dscrs_queue import dscrs_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_data,
	input  logic         pop,
	output queue_entry_t pop_data,
	output logic         empty,
	output logic         full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	queue_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/dscrs_front.sv =====
// front end: takes stream bytes and tags them with slot and offset
// depends on dscrs_pkg
`timescale 1ns / 1ps

module dscrs_front import dscrs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [7:0]   record_byte,
	input  logic         last,
	input  logic         queue_full,
	output logic         busy,
	output logic         push,
	output queue_entry_t push_data
);

	logic [5:0] byte_cnt_q;

	assign busy = queue_full;
	assign push = start && !queue_full;

	always_comb begin
		push_data.data = record_byte;
		push_data.last = last;
		push_data.slot = byte_cnt_q[5];
		push_data.off  = byte_cnt_q[4:0];
	end

	// early last restarts the stream at slot 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (push) begin
			byte_cnt_q <= last ? '0 : byte_cnt_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/dscrs_back.sv =====
// back end: crc update, blank tracking and field capture per slot
// depends on dscrs_pkg
`timescale 1ns / 1ps

module dscrs_back import dscrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            queue_empty,
	input  queue_entry_t    entry,
	output logic            pop,
	output slot_rec_t [1:0] slots,
	output logic            decide_req
);

	// erased slot: all fields clear, blank mark set
	localparam slot_rec_t SLOT_RESET = '{magic: '0, version: '0, generation: '0,
		small_fields: '0, shunt: '0, capacity: '0, crc_match: 1'b0, blank: 1'b1};

	logic [31:0] crc_q;
	logic [31:0] stored_crc_q [2];
	logic [31:0] crc_base, crc_next, stored_new;
	slot_rec_t [1:0] slots_q;
	logic decide_q;
	logic s;
	logic [1:0] lane;

	assign pop        = !queue_empty;
	assign slots      = slots_q;
	assign decide_req = decide_q;
	assign s          = entry.slot;
	assign lane       = entry.off[1:0];

	always_comb begin
		crc_base   = (entry.off == '0) ? ALL_ONES : crc_q;
		crc_next   = (entry.off < CRC_END_OFF) ? crc32_byte(crc_base, entry.data) : crc_base;
		stored_new = put_byte(stored_crc_q[s], lane, entry.data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= ALL_ONES;
			decide_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				slots_q[i]      <= SLOT_RESET;
				stored_crc_q[i] <= '0;
			end
		end else begin
			decide_q <= pop && entry.last;
			if (pop) begin
				crc_q <= crc_next;
				slots_q[s].blank <= (entry.data == BLANK_BYTE) &&
					((entry.off == '0) || slots_q[s].blank);
				case (entry.off[4:2])
					GRP_MAGIC: begin
						slots_q[s].magic <= put_byte(slots_q[s].magic, lane, entry.data);
					end
					GRP_VERSION: begin
						if (!lane[1]) begin
							slots_q[s].version[{lane[0], 3'b000} +: 8] <= entry.data;
						end
					end
					GRP_GEN: begin
						slots_q[s].generation <= put_byte(slots_q[s].generation, lane,
							entry.data);
					end
					GRP_SMALL: begin
						slots_q[s].small_fields <= put_byte(slots_q[s].small_fields, lane,
							entry.data);
					end
					GRP_SHUNT: begin
						slots_q[s].shunt <= put_byte(slots_q[s].shunt, lane, entry.data);
					end
					GRP_CAPACITY: begin
						slots_q[s].capacity <= put_byte(slots_q[s].capacity, lane,
							entry.data);
					end
					GRP_RESERVED: begin
					end
					GRP_CRC: begin
						stored_crc_q[s] <= stored_new;
						if (entry.off == LAST_OFF) begin
							slots_q[s].crc_match <= ((crc_base ^ ALL_ONES) == stored_new);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/dscrs_decide.sv =====
// two-stage decision: per-slot checks, then selection and result fields
// depends on dscrs_pkg
`timescale 1ns / 1ps

module dscrs_decide import dscrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            decide_req,
	input  slot_rec_t [1:0] slots,
	input  logic [15:0]     expected_version,
	input  logic [7:0]      max_slave_count,
	output logic            done,
	output logic [1:0]      status,
	output logic [15:0]     record_version,
	output logic [7:0]      slave_count,
	output logic [7:0]      sense_slave,
	output logic            invert_current,
	output logic            balance_enabled,
	output logic [31:0]     shunt_micro_ohms,
	output logic [31:0]     capacity_milli_ah,
	output logic [31:0]     next_generation,
	output logic            target_slot
);

	slot_flags_t flags_c [2];
	slot_flags_t flags_s1 [2];
	slot_view_t  view_s1 [2];
	logic        ge01_s1, ge10_s1, pend_s1;
	logic [15:0] exp_ver_s1;

	// stage 1 checks
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			logic [7:0] sc, ss, bal;
			logic       ver_eq, magic_ok;
			sc       = slots[i].small_fields[7:0];
			ss       = slots[i].small_fields[15:8];
			bal      = slots[i].small_fields[31:24];
			ver_eq   = (slots[i].version == expected_version);
			magic_ok = (slots[i].magic == REC_MAGIC);
			flags_c[i].rec_ok = magic_ok && (slots[i].version != '0) && (bal <= 8'd1) &&
				slots[i].crc_match;
			flags_c[i].valid = flags_c[i].rec_ok && ver_eq &&
				(sc != '0) && (sc <= max_slave_count) && (ss <= sc) &&
				(slots[i].shunt != '0) && (slots[i].shunt <= SHUNT_LIMIT) &&
				(slots[i].capacity != '0) && (slots[i].capacity <= CAPACITY_LIMIT);
			flags_c[i].exp_match = !slots[i].blank && magic_ok && ver_eq;
			flags_c[i].ver_ne    = !ver_eq;
			flags_c[i].blank     = slots[i].blank;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_req) begin
			for (int i = 0; i < 2; i++) begin
				flags_s1[i]              <= flags_c[i];
				view_s1[i].version       <= slots[i].version;
				view_s1[i].generation    <= slots[i].generation;
				view_s1[i].small_fields  <= slots[i].small_fields;
				view_s1[i].shunt         <= slots[i].shunt;
				view_s1[i].capacity      <= slots[i].capacity;
			end
			ge01_s1    <= (slots[0].generation >= slots[1].generation);
			ge10_s1    <= (slots[1].generation >= slots[0].generation);
			exp_ver_s1 <= expected_version;
		end
	end

	// stage 2 selection
	logic        v0, v1, first_wins, sel, have, m0, m1, has_meta, meta;
	status_t     status_c;
	logic [15:0] version_c;
	logic [31:0] next_gen_c;
	logic        target_c;

	always_comb begin
		v0         = flags_s1[0].valid;
		v1         = flags_s1[1].valid;
		first_wins = v0 && (!v1 || ge01_s1);
		sel        = !first_wins;
		have       = v0 || v1;
		m0         = !flags_s1[0].blank && flags_s1[0].rec_ok;
		m1         = !flags_s1[1].blank && flags_s1[1].rec_ok && (!m0 || ge10_s1);
		has_meta   = m0 || m1;
		meta       = m1;
		if (have) begin
			status_c  = ST_VALID;
			version_c = view_s1[sel].version;
		end else if (flags_s1[0].exp_match || flags_s1[1].exp_match) begin
			status_c  = ST_CORRUPT;
			version_c = exp_ver_s1;
		end else if (has_meta && flags_s1[meta].ver_ne) begin
			status_c  = ST_MISMATCH;
			version_c = view_s1[meta].version;
		end else if (flags_s1[0].blank && flags_s1[1].blank) begin
			status_c  = ST_BLANK;
			version_c = '0;
		end else begin
			status_c  = ST_CORRUPT;
			version_c = has_meta ? view_s1[meta].version : '0;
		end
		next_gen_c = have ? view_s1[sel].generation + 32'd1 : 32'd1;
		if (first_wins) begin
			target_c = 1'b1;
		end else if (v1 || flags_s1[0].blank) begin
			target_c = 1'b0;
		end else begin
			target_c = flags_s1[1].blank;
		end
	end

	logic        done_s2;
	status_t     status_s2;
	logic [15:0] version_s2;
	logic [7:0]  slave_count_s2, sense_slave_s2;
	logic        invert_s2, balance_s2, target_s2;
	logic [31:0] shunt_s2, capacity_s2, next_gen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			pend_s1 <= decide_req;
			done_s2 <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			status_s2      <= status_c;
			version_s2     <= version_c;
			slave_count_s2 <= have ? view_s1[sel].small_fields[7:0] : '0;
			sense_slave_s2 <= have ? view_s1[sel].small_fields[15:8] : '0;
			invert_s2      <= have && (view_s1[sel].small_fields[23:16] != '0);
			balance_s2     <= have && (view_s1[sel].small_fields[31:24] != '0);
			shunt_s2       <= have ? view_s1[sel].shunt : '0;
			capacity_s2    <= have ? view_s1[sel].capacity : '0;
			next_gen_s2    <= next_gen_c;
			target_s2      <= target_c;
		end
	end

	assign done              = done_s2;
	assign status            = status_s2;
	assign record_version    = version_s2;
	assign slave_count       = slave_count_s2;
	assign sense_slave       = sense_slave_s2;
	assign invert_current    = invert_s2;
	assign balance_enabled   = balance_s2;
	assign shunt_micro_ohms  = shunt_s2;
	assign capacity_milli_ah = capacity_s2;
	assign next_generation   = next_gen_s2;
	assign target_slot       = target_s2;

endmodule

// ===== rtl/core/dual_slot_config_record_selector.sv =====
// top level of the dual-slot configuration record selector
// depends on dscrs_pkg, dscrs_front, dscrs_queue, dscrs_back, dscrs_decide
`timescale 1ns / 1ps

// Reads two 32-byte flash records as a 64-byte stream, slot 0 then slot 1,
// one byte per transaction (start high while busy is low). The stream runs at
// one byte per cycle; busy only rises if the byte queue fills, which the back
// end prevents by draining one entry every cycle. The byte marked last yields
// one result, shown for a single cycle with done high. The last byte is
// pushed into the queue, read out and captured by the back end, then the two
// decision stages register in turn, and done rises with the second. The
// result cannot be held off, so it must be taken as shown.
// Register writes on cfg_we take effect at once and should only be made
// while no stream is in flight.
module dual_slot_config_record_selector import dscrs_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream transaction
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  record_byte,
	input  logic        last,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// result
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] record_version,
	output logic [7:0]  slave_count,
	output logic [7:0]  sense_slave,
	output logic        invert_current,
	output logic        balance_enabled,
	output logic [31:0] shunt_micro_ohms,
	output logic [31:0] capacity_milli_ah,
	output logic [31:0] next_generation,
	output logic        target_slot
);

	logic [15:0] expected_version_q;
	logic [7:0]  max_slave_count_q;

	// configuration registers, reset to version 1 and sixteen slaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= 16'd1;
			max_slave_count_q  <= 8'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_VERSION: expected_version_q <= cfg_data;
				CFG_MAX_SLAVE_COUNT:  max_slave_count_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front end tags each byte with its slot and offset
	queue_entry_t push_data, pop_data;
	logic push, pop, q_empty, q_full;

	dscrs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.record_byte (record_byte),
		.last        (last),
		.queue_full  (q_full),
		.busy        (busy),
		.push        (push),
		.push_data   (push_data)
	);

	// short queue decouples acceptance from the capture stage
	dscrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back end keeps the running crc, blank marks and captured fields
	slot_rec_t [1:0] slots;
	logic decide_req;

	dscrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.entry       (pop_data),
		.pop         (pop),
		.slots       (slots),
		.decide_req  (decide_req)
	);

	// decision pipeline picks the slot and forms the result
	dscrs_decide u_decide (
		.clk               (clk),
		.arst_n            (arst_n),
		.decide_req        (decide_req),
		.slots             (slots),
		.expected_version  (expected_version_q),
		.max_slave_count   (max_slave_count_q),
		.done              (done),
		.status            (status),
		.record_version    (record_version),
		.slave_count       (slave_count),
		.sense_slave       (sense_slave),
		.invert_current    (invert_current),
		.balance_enabled   (balance_enabled),
		.shunt_micro_ohms  (shunt_micro_ohms),
		.capacity_milli_ah (capacity_milli_ah),
		.next_generation   (next_generation),
		.target_slot       (target_slot)
	);

endmodule

// ===== rtl/core/dscrs_checker.sv =====
// port-level assertions for the dual-slot record selector, bound to the top
// depends on dscrs_pkg and dual_slot_config_record_selector_assert.svh
`timescale 1ns / 1ps

`include "dual_slot_config_record_selector_assert.svh"

module dscrs_checker import dscrs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last,
	input logic        done,
	input logic [1:0]  status,
	input logic [7:0]  slave_count,
	input logic [7:0]  sense_slave,
	input logic        invert_current,
	input logic        balance_enabled,
	input logic [31:0] shunt_micro_ohms,
	input logic [31:0] capacity_milli_ah,
	input logic [31:0] next_generation
);

	logic not_valid, is_valid, values_clear, limits_ok;
	assign not_valid = done && (status != ST_VALID);
	assign is_valid  = done && (status == ST_VALID);
	assign values_clear = (slave_count == 8'd0) && (sense_slave == 8'd0) && !invert_current &&
		!balance_enabled && (shunt_micro_ohms == 32'd0) && (capacity_milli_ah == 32'd0);
	assign limits_ok = (slave_count != 8'd0) && (sense_slave <= slave_count) &&
		(shunt_micro_ohms != 32'd0) && (capacity_milli_ah != 32'd0);

	// without a valid slot a save starts at generation one
	`DSCRS_ASSERT_IMP(a_gen_one, not_valid, next_generation == 32'd1, "next generation not one")

	// value fields stay zero unless a slot is valid
	`DSCRS_ASSERT_IMP(a_zero_values, not_valid, values_clear, "values not cleared")

	// a valid record obeys its own limits
	`DSCRS_ASSERT_IMP(a_valid_limits, is_valid, limits_ok, "valid record out of limits")

	// a last byte taken by the selector is followed by done
	`DSCRS_ASSERT_NXT(a_latency, start && !busy && last, ##3 done, "result missing")

endmodule

bind dual_slot_config_record_selector dscrs_checker u_dscrs_checker (.*);
